/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the frame receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define SFRX_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sfrx assertion failed");

// Check that a condition never holds, off while rst is high.
`define SFRX_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("sfrx forbidden condition seen");

`endif

/* hw/rtl/sfrx_pkg.sv */
// Types and constants of the serial frame receiver.
`timescale 1ns / 1ps

package sfrx_pkg;

  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // XOR of the fixed header and token bytes; the length byte is folded in later.
  localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
  } result_t;

endpackage

/* hw/rtl/sfrx_parser.sv */
// Frame parser state, timeout counter and per-word next-state logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfrx_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             step,
  input  logic             op,
  input  logic [7:0]       rx_byte,
  output sfrx_pkg::result_t res
);
  import sfrx_pkg::*;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'd0,
    PH_H1      = 3'd1,
    PH_H2      = 3'd2,
    PH_H3      = 3'd3,
    PH_LEN     = 3'd4,
    PH_TOKEN   = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] timeout_reload;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] next_index, next_index_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] idle_ticks, idle_ticks_next;
  phase_t     restart_phase;

  // A mismatching byte gets a second look as a possible start of header.
  assign restart_phase = (rx_byte == CH_U) ? PH_H1 : PH_SEARCH;

  always_comb begin
    phase_next        = phase;
    running_xor_next  = running_xor;
    bytes_left_next   = bytes_left;
    next_index_next   = next_index;
    frame_length_next = frame_length;
    idle_ticks_next   = idle_ticks;
    res               = '0;
    res.kind          = KIND_PAYLOAD;
    if (op == OP_TICK) begin
      if (idle_ticks != 8'd0) begin
        idle_ticks_next = idle_ticks - 8'd1;
      end else begin
        phase_next = PH_SEARCH;
      end
    end else begin
      idle_ticks_next = timeout_reload;
      unique case (phase)
        PH_SEARCH: phase_next = restart_phase;
        PH_H1:     phase_next = (rx_byte == CH_N) ? PH_H2 : restart_phase;
        PH_H2:     phase_next = (rx_byte == CH_E) ? PH_H3 : restart_phase;
        PH_H3:     phase_next = (rx_byte == CH_R) ? PH_LEN : restart_phase;
        PH_LEN: begin
          frame_length_next = rx_byte;
          bytes_left_next   = rx_byte;
          phase_next        = (rx_byte == 8'd0) ? PH_SEARCH : PH_TOKEN;
        end
        PH_TOKEN: begin
          if (rx_byte == CH_COLON) begin
            phase_next       = PH_PAYLOAD;
            running_xor_next = HDR_XOR ^ frame_length;
            next_index_next  = 8'd1;
          end else begin
            phase_next = restart_phase;
          end
        end
        PH_PAYLOAD: begin
          res.valid     = 1'b1;
          res.data_byte = rx_byte;
          if (bytes_left > 8'd1) begin
            running_xor_next = running_xor ^ rx_byte;
            next_index_next  = next_index + 8'd1;
            bytes_left_next  = bytes_left - 8'd1;
            res.kind         = KIND_PAYLOAD;
            res.byte_index   = next_index;
          end else begin
            phase_next      = PH_SEARCH;
            bytes_left_next = 8'd0;
            res.kind        = (running_xor == rx_byte) ? KIND_GOOD : KIND_BAD;
            res.byte_index  = frame_length;
          end
        end
        default: phase_next = PH_SEARCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SEARCH;
      timeout_reload <= TIMEOUT_RESET;
      running_xor    <= 8'd0;
      bytes_left     <= 8'd0;
      next_index     <= 8'd0;
      frame_length   <= 8'd0;
      idle_ticks     <= 8'd0;
    end else begin
      if (cfg_we) begin
        timeout_reload <= cfg_wdata;
      end
      if (step) begin
        phase        <= phase_next;
        running_xor  <= running_xor_next;
        bytes_left   <= bytes_left_next;
        next_index   <= next_index_next;
        frame_length <= frame_length_next;
        idle_ticks   <= idle_ticks_next;
      end
    end
  end

  `SFRX_NEVER(a_tick_no_result, op == OP_TICK && res.valid)
  `SFRX_ASSERT(a_frame_end_search,
               (step && res.valid && res.kind != KIND_PAYLOAD) |=> phase == PH_SEARCH)
  `SFRX_ASSERT(a_payload_index,
               (res.valid && res.kind == KIND_PAYLOAD) |-> next_index != 8'd0)

endmodule

/* hw/rtl/sfrx_out_reg.sv */
// Result register on the output side of the frame receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfrx_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sfrx_pkg::result_t res,
  input  logic              ready,
  output logic              valid,
  output sfrx_pkg::kind_t   kind,
  output logic [7:0]        data_byte,
  output logic [7:0]        byte_index
);
  import sfrx_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= res.kind;
      data_byte  <= res.data_byte;
      byte_index <= res.byte_index;
    end
  end

  `SFRX_ASSERT(a_no_overwrite, load |-> (!valid || ready))

endmodule

/* hw/rtl/serial_frame_receiver_xor_unit.sv */
// Top level of the serial frame receiver with XOR checksum.
`timescale 1ns / 1ps

// Serial frame receiver. Each input word is either a received byte
// (tuser = 0) or a timer tick (tuser = 1). Bytes are parsed for frames
// 'U','N','E','R', L, ':', then L bytes, the last of which is an XOR over
// all earlier frame bytes. Every payload byte leaves as one output word of
// kind payload with its position 1..L-1; the checksum byte leaves as a
// good or bad verdict carrying the received checksum and L. Ticks count
// down an inactivity counter reloaded by every byte from cfg_wdata's
// register (reset 5); a tick that finds it at zero drops the parser back
// to header search. A zero length drops the frame. Throughput is one word
// per clock while nothing stalls: a word is held in an input register,
// the parser updates its state from it while it is held, and any result
// goes into the output register, so a result reaches the master side by
// way of the input and output registers. The only stall is a result that
// finds the output register still full and not being taken; words that
// make no result never stall. Write cfg only while the unit is idle.
module serial_frame_receiver_xor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import sfrx_pkg::*;

  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       step;
  result_t    res;
  kind_t      out_kind;
  logic [7:0] out_data;
  logic [7:0] out_index;

  // Advance the held word unless its result would land on a full,
  // stalled output register.
  assign step = in_valid && (!res.valid || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Capture the word on acceptance; hold it while stalled.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser[0];
      in_byte <= s_axis_tdata;
    end
  end

  sfrx_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .op        (in_op),
    .rx_byte   (in_byte),
    .res       (res)
  );

  sfrx_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (step && res.valid),
    .res        (res),
    .ready      (m_axis_tready),
    .valid      (m_axis_tvalid),
    .kind       (out_kind),
    .data_byte  (out_data),
    .byte_index (out_index)
  );

  assign m_axis_tdata = {out_index, out_data};
  assign m_axis_tuser = out_kind;

endmodule

/* test/serial_frame_receiver_xor_unit_tb.sv */
// Self-checking bench for the serial frame receiver: directed frames, then random traffic.
`timescale 1ns / 1ps

module serial_frame_receiver_xor_unit_tb;
  import sfrx_pkg::*;

  // Parser position while hunting for and walking through a frame.
  typedef enum logic [2:0] {
    HUNT,
    SAW_U,
    SAW_N,
    SAW_E,
    WANT_LEN,
    WANT_COLON,
    IN_BODY
  } hunt_phase_t;

  // One report word as it leaves the master side.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
  } report_t;

  // One row of the directed script; fixed rows carry a hand-typed report.
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic       fixed;
    report_t    report;
  } script_row_t;

  localparam int SCRIPT_ROWS = 24;
  localparam int CHUNK_WORDS = 290;
  localparam int CHUNKS      = 6;
  localparam int DRAIN_CYCLES = 4;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic [0:0]  s_axis_tuser = 1'b0;    // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] data_byte, [15:8] byte_index
  logic [1:0]  m_axis_tuser;           // [1:0] kind

  serial_frame_receiver_xor_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow copy of the parser state and the timeout register.
  hunt_phase_t phase_q      = HUNT;
  logic [7:0]  xor_acc      = 8'h00;
  logic [7:0]  body_left    = 8'h00;
  logic [7:0]  next_pos     = 8'h00;
  logic [7:0]  frame_len    = 8'h00;
  logic [7:0]  idle_left    = 8'h00;
  logic [7:0]  reload_value = TIMEOUT_RESET;

  report_t     due_reports[$];
  report_t     no_report = '0;
  script_row_t script [0:SCRIPT_ROWS-1];

  int words_sent     = 0;
  int bad_count      = 0;
  int send_gap_pct   = 9;
  int recv_stall_pct = 46;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Randomly withhold tready on the master side.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // A mismatched byte may still open the next frame.
  function automatic hunt_phase_t after_miss(input logic [7:0] b);
    return (b == CH_U) ? SAW_U : HUNT;
  endfunction

  // Advance the shadow parser by one accepted word; return 1 when it reports.
  function automatic bit track_parser(input logic op, input logic [7:0] b,
                                      output report_t rep);
    bit made = 1'b0;
    rep = '0;
    if (op == OP_TICK) begin
      // idle counter at zero drops any partial frame
      if (idle_left != 8'h00) idle_left = idle_left - 8'd1;
      else phase_q = HUNT;
      return 1'b0;
    end
    idle_left = reload_value;
    case (phase_q)
      HUNT:     phase_q = after_miss(b);
      SAW_U:    phase_q = (b == CH_N) ? SAW_N : after_miss(b);
      SAW_N:    phase_q = (b == CH_E) ? SAW_E : after_miss(b);
      SAW_E:    phase_q = (b == CH_R) ? WANT_LEN : after_miss(b);
      WANT_LEN: begin
        frame_len = b;
        body_left = b;
        // zero length is a broken frame; the byte is consumed
        phase_q = (b == 8'h00) ? HUNT : WANT_COLON;
      end
      WANT_COLON: begin
        if (b == CH_COLON) begin
          phase_q  = IN_BODY;
          xor_acc  = HDR_XOR ^ frame_len;
          next_pos = 8'd1;
        end else begin
          phase_q = after_miss(b);
        end
      end
      IN_BODY: begin
        made = 1'b1;
        if (body_left > 8'd1) begin
          rep       = '{KIND_PAYLOAD, b, next_pos};
          xor_acc   = xor_acc ^ b;
          next_pos  = next_pos + 8'd1;
          body_left = body_left - 8'd1;
        end else begin
          // last byte of the body is the checksum
          rep       = '{(xor_acc == b) ? KIND_GOOD : KIND_BAD, b, frame_len};
          phase_q   = HUNT;
          body_left = 8'h00;
        end
      end
      default: phase_q = HUNT;
    endcase
    return made;
  endfunction

  // Offer one word on the slave side, hold it until taken, then log its report.
  task automatic feed_word(input logic op, input logic [7:0] b,
                           input logic fixed, input report_t fixed_rep);
    bit      took;
    report_t rep;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    // sample tready mid-cycle so the handshake is read race-free
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    words_sent++;
    if (track_parser(op, b, rep)) begin
      due_reports.push_back(fixed ? fixed_rep : rep);
    end
  endtask

  // Drop tvalid and hold off until every report is out and the pipe is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reload(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    reload_value = v;
  endtask

  task automatic feed_ticks(input int n);
    repeat (n) feed_word(OP_TICK, 8'($urandom), 1'b0, no_report);
  endtask

  // Frame byte with stray ticks before it, now and then a full timeout.
  task automatic feed_frame_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < 8) feed_ticks($urandom_range(1, 3));
    if ($urandom_range(0, 199) == 0) feed_ticks(int'(reload_value) + 2);
    feed_word(OP_BYTE, b, 1'b0, no_report);
  endtask

  // One frame with random content; negative len_pick draws the length.
  task automatic send_random_frame(input int len_pick);
    logic [7:0] hdr [0:5];
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    int         r;
    // leading noise, sometimes a lone 'U'
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 4)) begin
        b = ($urandom_range(0, 3) == 0) ? CH_U : 8'($urandom);
        feed_word(OP_BYTE, b, 1'b0, no_report);
      end
    end
    r = $urandom_range(0, 99);
    if (len_pick >= 0) len = 8'(len_pick);
    else if (r < 3) len = 8'd0;
    else if (r < 5) len = 8'd255;
    else if (r < 12) len = 8'd1;
    else len = 8'($urandom_range(2, 12));
    hdr[0] = CH_U;
    hdr[1] = CH_N;
    hdr[2] = CH_E;
    hdr[3] = CH_R;
    hdr[4] = len;
    hdr[5] = CH_COLON;
    // break the header now and then
    if ($urandom_range(0, 99) < 10) hdr[$urandom_range(0, 5)] = 8'($urandom);
    sum = 8'h00;
    for (int i = 0; i < 6; i++) begin
      sum = sum ^ hdr[i];
      feed_frame_byte(hdr[i]);
    end
    if (len != 8'd0) begin
      for (int i = 1; i < int'(len); i++) begin
        b   = 8'($urandom);
        sum = sum ^ b;
        feed_frame_byte(b);
      end
      // mostly a correct checksum, else flip one bit
      if ($urandom_range(0, 99) < 20) sum = sum ^ (8'd1 << $urandom_range(0, 7));
      feed_frame_byte(sum);
    end
    if ($urandom_range(0, 99) < 5) feed_ticks(int'(reload_value) + 2);
  endtask

  // Compare each taken report against the oldest one due.
  always @(negedge clk) begin : check_reports
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_reports.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("unexpected report: kind %0d data %h index %0d",
                   m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
        end
      end else begin
        want = due_reports.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.data_byte ||
            m_axis_tdata[15:8] !== want.byte_index) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("report mismatch: kind %0d/%0d data %h/%h index %0d/%0d (want/got)",
                     want.kind, m_axis_tuser, want.data_byte, m_axis_tdata[7:0],
                     want.byte_index, m_axis_tdata[15:8]);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] reload_plan [0:CHUNKS-1];
    // tick on a fresh parser, stray byte, zero length, a doubled 'U' before a
    // one-byte frame, then a short frame ending on a bad checksum
    script = '{
      '{OP_TICK, 8'hA5,     1'b0, '0},
      '{OP_BYTE, 8'h00,     1'b0, '0},
      '{OP_BYTE, CH_U,      1'b0, '0},
      '{OP_BYTE, CH_N,      1'b0, '0},
      '{OP_BYTE, CH_E,      1'b0, '0},
      '{OP_BYTE, CH_R,      1'b0, '0},
      '{OP_BYTE, 8'h00,     1'b0, '0},
      '{OP_BYTE, CH_U,      1'b0, '0},
      '{OP_BYTE, CH_U,      1'b0, '0},
      '{OP_BYTE, CH_N,      1'b0, '0},
      '{OP_BYTE, CH_E,      1'b0, '0},
      '{OP_BYTE, CH_R,      1'b0, '0},
      '{OP_BYTE, 8'h01,     1'b0, '0},
      '{OP_BYTE, CH_COLON,  1'b0, '0},
      '{OP_BYTE, HDR_XOR ^ 8'h01, 1'b1, '{KIND_GOOD, HDR_XOR ^ 8'h01, 8'd1}},
      '{OP_BYTE, CH_U,      1'b0, '0},
      '{OP_BYTE, CH_N,      1'b0, '0},
      '{OP_BYTE, CH_E,      1'b0, '0},
      '{OP_BYTE, CH_R,      1'b0, '0},
      '{OP_BYTE, 8'h03,     1'b0, '0},
      '{OP_BYTE, CH_COLON,  1'b0, '0},
      '{OP_BYTE, 8'hFF,     1'b1, '{KIND_PAYLOAD, 8'hFF, 8'd1}},
      '{OP_BYTE, 8'h00,     1'b1, '{KIND_PAYLOAD, 8'h00, 8'd2}},
      '{OP_BYTE, 8'hCB,     1'b1, '{KIND_BAD, 8'hCB, 8'd3}}
    };
    // timeout settings per random chunk, extremes included
    reload_plan[0] = 8'd0;
    reload_plan[1] = 8'd255;
    reload_plan[2] = 8'($urandom_range(1, 8));
    reload_plan[3] = 8'd1;
    reload_plan[4] = 8'd255;
    reload_plan[5] = 8'($urandom_range(0, 20));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part runs with the reset timeout
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      feed_word(script[i].op, script[i].rx_byte, script[i].fixed, script[i].report);
    end

    // random chunks: a slow receiver, then a slow sender, then run flat out
    for (int c = 0; c < CHUNKS; c++) begin
      settle();
      write_reload(reload_plan[c]);
      case (c / 2)
        0: begin
          send_gap_pct   = 9;
          recv_stall_pct = 46;
        end
        1: begin
          send_gap_pct   = 46;
          recv_stall_pct = 9;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      // one longest frame in the first flat-out chunk
      if (c == 4) send_random_frame(255);
      while (words_sent < SCRIPT_ROWS + (c + 1) * CHUNK_WORDS) send_random_frame(-1);
    end

    settle();
    repeat (8) @(posedge clk);
    if (bad_count == 0 && due_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sfrx_pkg.sv
hw/rtl/sfrx_parser.sv
hw/rtl/sfrx_out_reg.sv
hw/rtl/serial_frame_receiver_xor_unit.sv
test/serial_frame_receiver_xor_unit_tb.sv
